// File: hdl/greedy_power_coin_change_assert.svh
// Assertion macros for the greedy power coin change block.
// Used by the top level only; needs no package.
`ifndef GREEDY_POWER_COIN_CHANGE_ASSERT_SVH
`define GREEDY_POWER_COIN_CHANGE_ASSERT_SVH

// same-cycle implication
`define GPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define GPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/gpc_pkg.sv
// Shared types and constants for the greedy power coin change block.
// No dependencies.
`timescale 1ns / 1ps

package gpc_pkg;

  localparam int MaxPowers = 20;
  localparam int IdxW      = (MaxPowers > 1) ? $clog2(MaxPowers) : 1;
  localparam int BaseW     = 16;
  localparam int TopW      = 5;
  localparam int AmountW   = 31;
  localparam int DenomW    = 32;
  localparam int ProdW     = DenomW + BaseW;
  localparam int StepW     = $clog2(AmountW);

  localparam logic [DenomW-1:0] AmountMax = {1'b0, {AmountW{1'b1}}};
  localparam logic [DenomW-1:0] PowerSat  = {1'b1, {AmountW{1'b0}}};

  typedef struct packed {
    logic [BaseW-1:0]   base;
    logic [TopW-1:0]    top_exponent;
    logic [AmountW-1:0] amount;
  } gpc_in_t;

  typedef struct packed {
    logic [DenomW-1:0]  denomination;
    logic [AmountW-1:0] coin_count;
    logic               last;
  } gpc_out_t;

  typedef enum logic [2:0] {
    StIdle,
    StPow,
    StLoad,
    StDiv,
    StEmit
  } gpc_state_e;

  typedef struct packed {
    logic load_item;
    logic pow_step;
    logic load_digit;
    logic div_step;
    logic emit;
  } gpc_cmd_t;

  typedef struct packed {
    logic pow_last;
    logic div_last;
    logic digit_zero;
  } gpc_status_t;

endpackage

// File: hdl/gpc_datapath.sv
// Datapath: power table, power multiplier, shift-subtract divider, result register.
// Depends on gpc_pkg; driven by gpc_ctrl commands.
`timescale 1ns / 1ps

module gpc_datapath
  import gpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  gpc_in_t     in_i,
  input  gpc_cmd_t    cmd_i,
  output gpc_status_t status_o,
  output logic        out_valid_o,
  output gpc_out_t    out_o
);

  logic [DenomW-1:0]  power_mem [MaxPowers];
  logic [BaseW-1:0]   base_q;
  logic [IdxW-1:0]    top_q;
  logic [IdxW-1:0]    pow_idx_q;
  logic [IdxW-1:0]    dig_idx_q;
  logic [DenomW-1:0]  power_q, power_d;
  logic [AmountW-1:0] remainder_q;
  logic [DenomW-1:0]  divisor_q;
  logic [AmountW-1:0] part_q, part_d;
  logic [AmountW-1:0] quot_q, quot_d;
  logic [StepW-1:0]   step_q;
  logic               valid_q;
  gpc_out_t           result_q;
  logic [ProdW-1:0]   prod;
  logic [DenomW-1:0]  trial;
  logic [DenomW-1:0]  diff;
  logic               fits;
  logic               div_zero;
  logic [IdxW-1:0]    top_sat;

  always_comb begin
    if (32'(in_i.top_exponent) > 32'(MaxPowers - 1)) begin
      top_sat = IdxW'(MaxPowers - 1);
    end else begin
      top_sat = IdxW'(in_i.top_exponent);
    end
  end

  always_comb begin
    prod = ProdW'(power_q) * ProdW'(base_q);
    if (prod > ProdW'(AmountMax)) begin
      power_d = PowerSat;
    end else begin
      power_d = prod[DenomW-1:0];
    end
  end

  always_comb begin
    trial  = {part_q, quot_q[AmountW-1]};
    diff   = trial - divisor_q;
    fits   = (trial >= divisor_q);
    part_d = fits ? diff[AmountW-1:0] : trial[AmountW-1:0];
    quot_d = {quot_q[AmountW-2:0], fits};
  end

  assign div_zero = (divisor_q == '0);

  assign status_o.pow_last   = (pow_idx_q == top_q);
  assign status_o.div_last   = div_zero || (step_q == StepW'(AmountW - 1));
  assign status_o.digit_zero = (dig_idx_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.pow_step) begin
      power_mem[pow_idx_q] <= power_q;
    end
    if (cmd_i.load_digit) begin
      divisor_q <= power_mem[dig_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      base_q  <= in_i.base;
      top_q   <= top_sat;
      power_q <= DenomW'(1);
    end else if (cmd_i.pow_step) begin
      power_q <= power_d;
    end
    if (cmd_i.load_digit) begin
      quot_q <= remainder_q;
      part_q <= '0;
    end else if (cmd_i.div_step) begin
      quot_q <= quot_d;
      part_q <= part_d;
    end
    if (cmd_i.emit) begin
      result_q.denomination <= divisor_q;
      result_q.coin_count   <= div_zero ? '0 : quot_q;
      result_q.last         <= (dig_idx_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pow_idx_q   <= '0;
      dig_idx_q   <= '0;
      remainder_q <= '0;
      step_q      <= '0;
      valid_q     <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cmd_i.load_item) begin
        pow_idx_q   <= '0;
        dig_idx_q   <= top_sat;
        remainder_q <= in_i.amount;
      end else if (cmd_i.pow_step) begin
        pow_idx_q <= pow_idx_q + IdxW'(1);
      end
      if (cmd_i.load_digit) begin
        step_q <= '0;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + StepW'(1);
      end
      if (cmd_i.emit) begin
        if (!div_zero) begin
          remainder_q <= part_q;
        end
        if (dig_idx_q != '0) begin
          dig_idx_q <= dig_idx_q - IdxW'(1);
        end
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = result_q;

endmodule

// File: hdl/gpc_ctrl.sv
// Controller state machine: sequences power build, per-digit divide and emit.
// Depends on gpc_pkg; commands gpc_datapath.
`timescale 1ns / 1ps

module gpc_ctrl
  import gpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  gpc_status_t status_i,
  output gpc_cmd_t    cmd_o
);

  gpc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = (state_q != StIdle);
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load_item = 1'b1;
          state_d         = StPow;
        end
      end
      StPow: begin
        cmd_o.pow_step = 1'b1;
        if (status_i.pow_last) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        cmd_o.load_digit = 1'b1;
        state_d          = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        state_d    = status_i.digit_zero ? StIdle : StLoad;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// File: hdl/greedy_power_coin_change.sv
// Top level of the greedy power coin change block: controller plus datapath.
// Depends on gpc_pkg, gpc_ctrl, gpc_datapath and greedy_power_coin_change_assert.svh.
//
// An item transfers when start is high and busy is low. With k the top exponent
// (capped at 19) the block first builds k+1 powers, one per cycle through a 32x16
// multiplier, then for each denomination from base^k down to base^0 it runs a
// one-bit-per-cycle restoring divider over the 31-bit remainder (read, 31 steps,
// emit per denomination; fewer steps when the denomination is zero). Each result
// is shown for exactly one cycle on out_o, flagged by out_valid_o; the receiver
// cannot stall it. The base^0 result carries last and shows while busy is low.
`timescale 1ns / 1ps
`include "greedy_power_coin_change_assert.svh"

module greedy_power_coin_change
  import gpc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  gpc_in_t  in_i,
  output logic     out_valid_o,
  output gpc_out_t out_o
);

  gpc_cmd_t    cmd;
  gpc_status_t status;

  gpc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  gpc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  `GPC_ASSERT_NEXT(a_start_sets_busy, clk_i, rst_ni, start && !busy, busy)
  `GPC_ASSERT_NEXT(a_valid_single, clk_i, rst_ni, out_valid_o, !out_valid_o)
  `GPC_ASSERT_IMPL(a_last_when_idle, clk_i, rst_ni, out_valid_o && out_o.last, !busy)
  `GPC_ASSERT_IMPL(a_zero_denom_no_coins, clk_i, rst_ni,
                   out_valid_o && (out_o.denomination == '0), out_o.coin_count == '0)

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for greedy_power_coin_change: directed and random coin-change requests.
// A clocked driver feeds requests from a queue, and a monitor compares each result with a predictor.
// Depends on gpc_pkg and the greedy_power_coin_change RTL.
`timescale 1ns / 1ps

module tb_top;
  import gpc_pkg::*;

  typedef struct {
    gpc_in_t req;
    int      gap;
    bit      drain;
  } pay_req_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  gpc_in_t  in_i = '0;
  logic     out_valid_o;
  gpc_out_t out_o;

  pay_req_t pay_q[$];
  gpc_out_t coin_q[$];
  logic     xfer_q = 1'b0;
  int       gap_left = 0;
  int       n_errors = 0;
  int       n_requests = 0;
  int       n_results = 0;
  int       n_saturated = 0;
  int       n_zero_base = 0;
  int       n_total = 0;

  greedy_power_coin_change i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_o      (out_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void predict_change(gpc_in_t req);
    logic [63:0]        pw;
    logic [DenomW-1:0]  powers[MaxPowers];
    logic [DenomW-1:0]  rest;
    logic [DenomW-1:0]  denom;
    logic [DenomW-1:0]  cnt;
    int                 top;
    gpc_out_t           res;
    top = (req.top_exponent > MaxPowers - 1) ? MaxPowers - 1 : int'(req.top_exponent);
    pw = 64'd1;
    for (int i = 0; i <= top; i++) begin
      powers[i] = pw[DenomW-1:0];
      pw = pw * req.base;
      if (pw > AmountMax) begin
        pw = PowerSat;
      end
    end
    rest = {1'b0, req.amount};
    for (int i = top; i >= 0; i--) begin
      denom = powers[i];
      cnt = '0;
      if (denom != '0) begin
        cnt = rest / denom;
        rest = rest % denom;
      end
      if (denom == PowerSat) begin
        n_saturated++;
      end
      res.denomination = denom;
      res.coin_count = cnt[AmountW-1:0];
      res.last = (i == 0);
      coin_q.insert(coin_q.size(), res);
    end
  endfunction

  // Monitor: sample transfers and results at the rising edge.
  always @(posedge clk_i) begin
    gpc_out_t want;
    if (rst_ni) begin
      xfer_q <= start && !busy;
      if (out_valid_o) begin
        n_results++;
        if (coin_q.size() == 0) begin
          $error("unexpected result: denomination %0d, coin_count %0d, last %0d",
                 out_o.denomination, out_o.coin_count, out_o.last);
          n_errors++;
        end else begin
          want = coin_q.pop_front();
          if (out_o.denomination !== want.denomination) begin
            $error("denomination: expected %0d, got %0d", want.denomination,
                   out_o.denomination);
            n_errors++;
          end
          if (out_o.coin_count !== want.coin_count) begin
            $error("coin_count: expected %0d, got %0d", want.coin_count, out_o.coin_count);
            n_errors++;
          end
          if (out_o.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_o.last);
            n_errors++;
          end
        end
      end
      if (start && !busy) begin
        n_requests++;
        if (in_i.base == '0) begin
          n_zero_base++;
        end
        predict_change(in_i);
      end
    end
  end

  // Driver: change inputs at the falling edge.
  always @(negedge clk_i) begin
    logic    nxt_start;
    gpc_in_t nxt_in;
    nxt_start = 1'b0;
    nxt_in = gpc_in_t'($bits(gpc_in_t)'({$urandom, $urandom}));
    if (rst_ni) begin
      if (xfer_q && start) begin
        void'(pay_q.pop_front());
        if (pay_q.size() > 0) begin
          gap_left = pay_q[0].gap;
        end
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (pay_q.size() > 0) begin
        if (!(pay_q[0].drain && (coin_q.size() != 0 || busy))) begin
          nxt_start = 1'b1;
          nxt_in = pay_q[0].req;
        end
      end
    end
    start <= nxt_start;
    in_i <= nxt_in;
  end

  task automatic add_req(input logic [BaseW-1:0] base, input logic [TopW-1:0] top,
                         input logic [AmountW-1:0] amount, input int gap, input bit drain);
    pay_req_t r;
    r.req.base = base;
    r.req.top_exponent = top;
    r.req.amount = amount;
    r.gap = gap;
    r.drain = drain;
    pay_q.insert(pay_q.size(), r);
  endtask

  function automatic int rand_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 13));
  endfunction

  initial begin
    logic [BaseW-1:0]   b;
    logic [TopW-1:0]    k;
    logic [AmountW-1:0] a;
    int                 n_random;

    add_req(16'd2, 5'd0, 31'd0, 0, 1'b0);
    add_req(16'd2, 5'd19, AmountMax[AmountW-1:0], 0, 1'b0);
    add_req(16'd1, 5'd4, 31'd12345, rand_gap(), 1'b0);
    add_req(16'd1, 5'd0, AmountMax[AmountW-1:0], 0, 1'b0);
    add_req(16'd0, 5'd5, 31'd777, rand_gap(), 1'b0);
    add_req(16'd0, 5'd0, 31'd9, 0, 1'b0);
    add_req(16'hFFFF, 5'd19, AmountMax[AmountW-1:0], 0, 1'b0);
    add_req(16'hFFFF, 5'd2, 31'h5555_5555, rand_gap(), 1'b0);
    add_req(16'd10, 5'd9, 31'd1234567890, 0, 1'b0);
    add_req(16'd3, 5'd20, 31'h2AAA_AAAA, rand_gap(), 1'b1);
    add_req(16'd7, 5'd31, 31'd1000000, 0, 1'b0);
    add_req(16'd2, 5'd30, 31'd1 << 30, 0, 1'b0);
    add_req(16'h8000, 5'd3, 31'h4000_0000, rand_gap(), 1'b0);
    add_req(16'd46341, 5'd2, AmountMax[AmountW-1:0], 0, 1'b0);
    add_req(16'd5, 5'd12, 31'd0, 0, 1'b0);
    add_req(16'd2, 5'd16, 31'd65536, rand_gap(), 1'b0);

    n_random = 104;
    for (int i = 0; i < n_random; i++) begin
      case ($urandom_range(0, 9))
        0:       b = '0;
        1:       b = 16'd1;
        2, 3, 4: b = BaseW'($urandom_range(2, 16));
        5, 6:    b = BaseW'($urandom_range(17, 300));
        default: b = BaseW'($urandom);
      endcase
      k = ($urandom_range(0, 9) == 0) ? TopW'($urandom_range(20, 31))
                                      : TopW'($urandom_range(0, 19));
      case ($urandom_range(0, 3))
        0:       a = AmountW'($urandom_range(0, 1000));
        1:       a = AmountMax[AmountW-1:0] - AmountW'($urandom_range(0, 1000));
        default: a = AmountW'($urandom);
      endcase
      add_req(b, k, a, (i >= n_random - 20) ? 0 : rand_gap(), i == n_random / 2);
    end
    n_total = pay_q.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (n_requests < n_total) @(posedge clk_i);
    while (coin_q.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);

    $display("Covered %0d coin-change requests with %0d results checked,", n_requests, n_results);
    $display("including %0d saturated denominations and %0d requests with base zero.",
             n_saturated, n_zero_base);
    if (n_errors == 0 && coin_q.size() == 0) begin
      $display("greedy_power_coin_change test passed");
    end else begin
      $display("greedy_power_coin_change test failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("greedy_power_coin_change test failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/gpc_pkg.sv
hdl/gpc_datapath.sv
hdl/gpc_ctrl.sv
hdl/greedy_power_coin_change.sv
tb/tb_top.sv
